>>> sv/masm_pkg.sv
// masm_pkg: shared types, constants and codes for the matrix engine.
// No dependencies; imported by every module of the block.
package masm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int FRAC_BITS   = 16;
    localparam int DEPTH       = MAX_DIM * MAX_DIM;
    localparam int AW          = $clog2(DEPTH);
    localparam int DW          = $clog2(MAX_DIM + 1);
    localparam int KW          = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW          = $clog2(DEPTH + 1);
    localparam int ACC_W       = 64 + KW + 1;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SUB   = 2'd1,
        OP_MUL   = 2'd2,
        OP_SCALE = 2'd3
    } op_t;

    localparam logic [2:0] REG_OPERATION   = 3'd0;
    localparam logic [2:0] REG_ROWS_FIRST  = 3'd1;
    localparam logic [2:0] REG_COLS_FIRST  = 3'd2;
    localparam logic [2:0] REG_ROWS_SECOND = 3'd3;
    localparam logic [2:0] REG_COLS_SECOND = 3'd4;
    localparam logic [2:0] REG_SCALE       = 3'd5;

    typedef struct packed {
        logic        func;
        logic [31:0] element_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        dimension_error;
        logic        last_result;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  rows_first;
        logic [3:0]  cols_first;
        logic [3:0]  rows_second;
        logic [3:0]  cols_second;
        logic [31:0] scale_factor;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic          wr_first;
        logic          wr_second;
        logic [AW-1:0] wr_addr;
        logic [AW-1:0] rd_addr_a;
        logic [AW-1:0] rd_addr_b;
        logic          acc_clear;
        logic          mul_en;
        logic          acc_en;
        logic          load_out;
        logic          err_out;
        logic          last_out;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;
    } dp_stat_t;

endpackage

>>> sv/masm_datapath.sv
// masm_datapath: operand memories, multiplier, wide accumulator and result register.
// Depends on masm_pkg; driven by masm_ctrl commands.
module masm_datapath
    import masm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic [31:0] wr_data,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output out_item_t   m_data,
    output logic        m_valid,
    input  logic        m_ready
);

    logic [31:0] first_mem [DEPTH];
    logic [31:0] second_mem [DEPTH];
    logic [31:0] a_reg, b_reg;
    logic signed [63:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    out_item_t out_reg;
    logic out_valid_reg;

    logic signed [32:0] sum33;
    logic signed [ACC_W-1:0] rnd, shr;
    logic [31:0] res;

    always_ff @(posedge aclk) begin
        if (cmd.wr_first)  first_mem[cmd.wr_addr]  <= wr_data;
        if (cmd.wr_second) second_mem[cmd.wr_addr] <= wr_data;
        a_reg <= first_mem[cmd.rd_addr_a];
        b_reg <= second_mem[cmd.rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            if (cfg.operation == OP_SCALE)
                prod_reg <= $signed(a_reg) * $signed(cfg.scale_factor);
            else
                prod_reg <= $signed(a_reg) * $signed(b_reg);
        end
        if (cmd.acc_clear)
            acc_reg <= '0;
        else if (cmd.acc_en)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    always_comb begin
        if (cfg.operation == OP_ADD)
            sum33 = $signed({a_reg[31], a_reg}) + $signed({b_reg[31], b_reg});
        else
            sum33 = $signed({a_reg[31], a_reg}) - $signed({b_reg[31], b_reg});
        rnd = acc_reg;
        if (FRAC_BITS > 0)
            rnd = acc_reg + (ACC_W'(1) <<< (FRAC_BITS - 1));
        shr = rnd >>> FRAC_BITS;
        if (cfg.operation == OP_ADD || cfg.operation == OP_SUB) begin
            if (sum33 > 33'sh0_7FFF_FFFF)      res = 32'h7FFF_FFFF;
            else if (sum33 < -33'sh0_8000_0000) res = 32'h8000_0000;
            else                                res = sum33[31:0];
        end else begin
            if (shr > ACC_W'(64'sh7FFF_FFFF))        res = 32'h7FFF_FFFF;
            else if (shr < -ACC_W'(64'sh8000_0000))  res = 32'h8000_0000;
            else                                     res = shr[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            out_reg.result_value    <= cmd.err_out ? 32'd0 : res;
            out_reg.dimension_error <= cmd.err_out;
            out_reg.last_result     <= cmd.last_out;
        end
    end

    assign m_data = out_reg;
    assign m_valid = out_valid_reg;
    assign stat.out_busy = out_valid_reg && !m_ready;

endmodule

>>> sv/masm_ctrl.sv
// masm_ctrl: load counters, dimension check and result sequencing state machine.
// Depends on masm_pkg; commands masm_datapath.
module masm_ctrl
    import masm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  in_item_t s_data,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic [CW-1:0] cnt1_reg, cnt1_next, cnt2_reg, cnt2_next;
    logic [DW-1:0] i_reg, i_next, j_reg, j_next;
    logic [KW:0]   k_reg, k_next;
    logic err_reg, err_next;

    logic ok, fire;
    logic [CW-1:0] tot1, tot2;
    logic [DW-1:0] rr, cc;
    logic is_mul;

    function automatic logic dim_ok(input logic [3:0] d);
        return d >= 4'd1 && d <= 4'(MAX_DIM);
    endfunction

    always_comb begin
        ok = dim_ok(cfg.rows_first) && dim_ok(cfg.cols_first);
        if (cfg.operation != OP_SCALE) begin
            ok = ok && dim_ok(cfg.rows_second) && dim_ok(cfg.cols_second);
            if (cfg.operation == OP_MUL)
                ok = ok && cfg.cols_first == cfg.rows_second;
            else
                ok = ok && cfg.rows_first == cfg.rows_second
                        && cfg.cols_first == cfg.cols_second;
        end
        tot1 = CW'(cfg.rows_first) * CW'(cfg.cols_first);
        tot2 = CW'(cfg.rows_second) * CW'(cfg.cols_second);
        is_mul = cfg.operation == OP_MUL;
        rr = DW'(cfg.rows_first);
        cc = is_mul ? DW'(cfg.cols_second) : DW'(cfg.cols_first);
    end

    assign s_ready = state_reg == ST_LOAD && !err_reg && !stat.out_busy;
    assign fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt1_reg  <= '0;
            cnt2_reg  <= '0;
            err_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt1_reg  <= cnt1_next;
            cnt2_reg  <= cnt2_next;
            err_reg   <= err_next;
        end
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
    end

    always_comb begin
        state_next = state_reg;
        cnt1_next = cnt1_reg;
        cnt2_next = cnt2_reg;
        err_next = 1'b0;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        cmd = '0;
        cmd.wr_addr = cnt1_reg[AW-1:0];
        cmd.rd_addr_a = is_mul ? AW'(i_reg) * AW'(cfg.cols_first) + AW'(k_reg)
                               : AW'(i_reg) * AW'(cc) + AW'(j_reg);
        cmd.rd_addr_b = is_mul ? AW'(k_reg) * AW'(cfg.cols_second) + AW'(j_reg)
                               : AW'(i_reg) * AW'(cc) + AW'(j_reg);
        if (err_reg) begin
            cmd.load_out = 1'b1;
            cmd.err_out = 1'b1;
            cmd.last_out = 1'b1;
        end
        unique case (state_reg)
            ST_LOAD: begin
                if (fire) begin
                    if (!ok) begin
                        cnt1_next = '0;
                        cnt2_next = '0;
                        err_next = 1'b1;
                    end else begin
                        if (!s_data.func) begin
                            if (cnt1_reg < tot1) begin
                                cmd.wr_first = 1'b1;
                                cnt1_next = cnt1_reg + 1'b1;
                            end
                        end else if (cfg.operation != OP_SCALE && cnt2_reg < tot2) begin
                            cmd.wr_second = 1'b1;
                            cmd.wr_addr = cnt2_reg[AW-1:0];
                            cnt2_next = cnt2_reg + 1'b1;
                        end
                        if (!(s_data.func && cfg.operation == OP_SCALE) &&
                            cnt1_next >= tot1 &&
                            (cfg.operation == OP_SCALE || cnt2_next >= tot2)) begin
                            state_next = ST_READ;
                            i_next = '0;
                            j_next = '0;
                            k_next = '0;
                        end
                    end
                end
            end
            ST_READ: begin
                // operand reads registered this cycle
                cmd.acc_clear = k_reg == '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_en = 1'b1;
                if (is_mul && k_reg + 1'b1 < (KW+1)'(cfg.cols_first)) begin
                    k_next = k_reg + 1'b1;
                    state_next = ST_READ;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // for add/sub, a_reg/b_reg still hold this element's operands
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    cmd.last_out = i_reg == rr - 1'b1 && j_reg == cc - 1'b1;
                    k_next = '0;
                    if (cmd.last_out) begin
                        cnt1_next = '0;
                        cnt2_next = '0;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_READ;
                        if (j_reg == cc - 1'b1) begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end else begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    a_err_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg |-> state_reg == ST_LOAD) else $error("error result outside load");
    a_cnt1_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt1_reg <= CW'(DEPTH)) else $error("first count overflow");
    a_cnt2_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt2_reg <= CW'(DEPTH)) else $error("second count overflow");
    a_emit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !stat.out_busy) else $error("result overwritten");

endmodule

>>> sv/masm_cfg.sv
// masm_cfg: configuration register file.
// Depends on masm_pkg.
module masm_cfg
    import masm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.operation    <= OP_MUL;
            cfg_reg.rows_first   <= 4'd8;
            cfg_reg.cols_first   <= 4'd8;
            cfg_reg.rows_second  <= 4'd8;
            cfg_reg.cols_second  <= 4'd8;
            cfg_reg.scale_factor <= 32'd65536;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_OPERATION:   cfg_reg.operation    <= cfg_data[1:0];
                REG_ROWS_FIRST:  cfg_reg.rows_first   <= cfg_data[3:0];
                REG_COLS_FIRST:  cfg_reg.cols_first   <= cfg_data[3:0];
                REG_ROWS_SECOND: cfg_reg.rows_second  <= cfg_data[3:0];
                REG_COLS_SECOND: cfg_reg.cols_second  <= cfg_data[3:0];
                REG_SCALE:       cfg_reg.scale_factor <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/matrix_add_sub_mul_scale_unit.sv
// matrix_add_sub_mul_scale_unit: top level of the Q16.16 matrix engine.
// Depends on masm_pkg, masm_cfg, masm_ctrl, masm_datapath.
//
//  channel | ports                        | payload
//  input   | s_valid s_ready s_data       | in_item_t
//  result  | m_valid m_ready m_data       | out_item_t
//  config  | cfg_valid cfg_ready          | cfg_index, cfg_data
//
// Load: one element per cycle while s_ready is high. Results: add/sub/scale
// step through read, multiply, accumulate and emit per element; multiply
// repeats read, multiply and accumulate per term (one shared multiplier).
// Reset clears load counters and state, presets config; stores undefined.
// A stalled result holds the sequencer; loading pauses while a result waits.
module matrix_add_sub_mul_scale_unit
    import masm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    masm_cfg u_cfg (
        .aclk, .aresetn, .cfg_valid, .cfg_index, .cfg_data, .cfg
    );

    masm_ctrl u_ctrl (
        .aclk, .aresetn, .cfg, .s_data, .s_valid, .s_ready, .stat, .cmd
    );

    masm_datapath u_dp (
        .aclk, .aresetn, .cfg, .wr_data(s_data.element_value), .cmd, .stat,
        .m_data, .m_valid, .m_ready
    );

endmodule

>>> sim/tb_matrix_add_sub_mul_scale_unit.sv
// Testbench for matrix_add_sub_mul_scale_unit: directed table then random matrices,
// every result beat checked against an in-bench Q16.16 matrix predictor.
// Depends on masm_pkg and the RTL of the matrix engine.
module tb_matrix_add_sub_mul_scale_unit
    import masm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    matrix_add_sub_mul_scale_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    localparam int LIMIT = 2000000;

    // predictor state
    op_t                mx_op;
    logic [3:0]         mx_r1, mx_c1, mx_r2, mx_c2;
    logic signed [31:0] mx_scale;
    logic signed [31:0] first_mat [DEPTH];
    logic signed [31:0] second_mat [DEPTH];
    int                 first_fill, second_fill;

    out_item_t pending_results[$];
    int        n_predicted;
    int        mismatches;
    int        beats_in, beats_out, error_beats;
    int        cycle_count;
    int        sender_idle, receiver_idle;
    bit        hold_off;

    typedef struct {
        logic              func;
        logic [31:0]       value;
        bit                has_gold;
        out_item_t         gold;
    } row_t;

    function automatic logic signed [31:0] round_sat(logic signed [70:0] acc);
        logic signed [70:0] q;
        q = (acc + (71'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (q > 71'sh7fffffff) return 32'h7fffffff;
        if (q < -71'sh80000000) return 32'h80000000;
        return q[31:0];
    endfunction

    function automatic logic signed [31:0] sat33(logic signed [32:0] v);
        if (v > 33'sh07fffffff) return 32'h7fffffff;
        if (v < -33'sh080000000) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic bit dim_good(logic [3:0] d);
        return d >= 1 && d <= MAX_DIM;
    endfunction

    function automatic bit shapes_fit();
        if (!dim_good(mx_r1) || !dim_good(mx_c1)) return 0;
        if (mx_op == OP_SCALE) return 1;
        if (!dim_good(mx_r2) || !dim_good(mx_c2)) return 0;
        if (mx_op == OP_MUL) return mx_c1 == mx_r2;
        return mx_r1 == mx_r2 && mx_c1 == mx_c2;
    endfunction

    function automatic void write_reg(logic [2:0] idx, logic [31:0] d);
        case (idx)
            REG_OPERATION:   mx_op = op_t'(d[1:0]);
            REG_ROWS_FIRST:  mx_r1 = d[3:0];
            REG_COLS_FIRST:  mx_c1 = d[3:0];
            REG_ROWS_SECOND: mx_r2 = d[3:0];
            REG_COLS_SECOND: mx_c2 = d[3:0];
            REG_SCALE:       mx_scale = d;
            default: ;
        endcase
    endfunction

    task automatic push_result(logic [31:0] v, logic e, logic l);
        out_item_t o;
        o.result_value = v;
        o.dimension_error = e;
        o.last_result = l;
        pending_results.push_back(o);
        n_predicted++;
    endtask

    task automatic predict_element(logic func, logic signed [31:0] val);
        int t1, t2, rr, cc;
        logic signed [70:0] acc;
        logic signed [31:0] v;
        if (!shapes_fit()) begin
            first_fill = 0;
            second_fill = 0;
            push_result('0, 1'b1, 1'b1);
            return;
        end
        t1 = mx_r1 * mx_c1;
        t2 = mx_r2 * mx_c2;
        if (func == 1'b0) begin
            if (first_fill < t1) first_mat[first_fill++] = val;
        end else begin
            if (mx_op == OP_SCALE) return;
            if (second_fill < t2) second_mat[second_fill++] = val;
        end
        if (first_fill < t1) return;
        if (mx_op != OP_SCALE && second_fill < t2) return;
        rr = mx_r1;
        cc = (mx_op == OP_MUL) ? mx_c2 : mx_c1;
        for (int i = 0; i < rr; i++) begin
            for (int j = 0; j < cc; j++) begin
                case (mx_op)
                    OP_ADD: v = sat33(33'(first_mat[i*cc+j]) + 33'(second_mat[i*cc+j]));
                    OP_SUB: v = sat33(33'(first_mat[i*cc+j]) - 33'(second_mat[i*cc+j]));
                    OP_MUL: begin
                        acc = '0;
                        for (int k = 0; k < mx_c1; k++)
                            acc += 71'(first_mat[i*mx_c1+k]) * 71'(second_mat[k*mx_c2+j]);
                        v = round_sat(acc);
                    end
                    default: v = round_sat(71'(first_mat[i*cc+j]) * 71'(mx_scale));
                endcase
                push_result(v, 1'b0, (i*cc + j + 1 == rr*cc));
            end
        end
        first_fill = 0;
        second_fill = 0;
    endtask

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_out++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", m_data);
            end else begin
                want = pending_results.pop_front();
                if (want.dimension_error) error_beats++;
                if (m_data.result_value !== want.result_value ||
                    m_data.dimension_error !== want.dimension_error ||
                    m_data.last_result !== want.last_result) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: value exp %h got %h, err exp %b got %b, last exp %b got %b",
                                 want.result_value, m_data.result_value,
                                 want.dimension_error, m_data.dimension_error,
                                 want.last_result, m_data.last_result);
                end
            end
        end
    end

    // receiver ready with random stalls and one long hold-off
    always @(negedge aclk) begin
        if (!aresetn || hold_off) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    task automatic send_element(logic func, logic [31:0] val);
        if ($urandom_range(99) < sender_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < sender_idle) @(negedge aclk);
        end
        s_data <= {func, val};
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_element(func, val);
        beats_in++;
        @(negedge aclk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        while (guard < 3 * MAX_DIM * MAX_DIM + 40) begin
            guard++;
            @(negedge aclk);
        end
    endtask

    task automatic set_reg(logic [2:0] idx, logic [31:0] d);
        cfg_index <= idx;
        cfg_data <= d;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        write_reg(idx, d);
        @(negedge aclk);
    endtask

    task automatic set_shape(op_t op, int r1, int c1, int r2, int c2, logic [31:0] sc);
        drain();
        set_reg(REG_OPERATION, 32'(op));
        set_reg(REG_ROWS_FIRST, 32'(r1));
        set_reg(REG_COLS_FIRST, 32'(c1));
        set_reg(REG_ROWS_SECOND, 32'(r2));
        set_reg(REG_COLS_SECOND, 32'(c2));
        set_reg(REG_SCALE, sc);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(8'hff)) - 128) <<< 16;
            3: return $urandom_range(32'h3ffff) - 32'h1ffff;
            default: return $urandom();
        endcase
    endfunction

    // random content, well-formed sequences mostly
    task automatic random_phase(int items);
        int n, r1, c1, r2, c2, t1, t2, opn;
        op_t op;
        n = 0;
        while (n < items) begin
            opn = $urandom_range(3);
            op = op_t'(opn);
            r1 = $urandom_range(1, 3);
            c1 = $urandom_range(1, 3);
            if ($urandom_range(19) == 0) begin
                r1 = 8;
                c1 = 8;
            end
            r2 = (op == OP_MUL) ? c1 : r1;
            c2 = (op == OP_MUL) ? $urandom_range(1, 3) : c1;
            if ($urandom_range(15) == 0) c2 = $urandom_range(15);
            set_shape(op, r1, c1, r2, c2, rand_value());
            t1 = r1 * c1;
            t2 = r2 * c2;
            if (!shapes_fit()) begin
                send_element($urandom_range(1), rand_value());
                n++;
                continue;
            end
            for (int i = 0; i < t1 + ((op == OP_SCALE) ? 0 : t2); i++) begin
                if ($urandom_range(9) == 0) begin
                    send_element($urandom_range(1), rand_value());
                end else if (op == OP_SCALE) begin
                    send_element(1'b0, rand_value());
                end else begin
                    send_element(first_fill < t1 && (second_fill >= t2 ||
                                 $urandom_range(1)) ? 1'b0 : 1'b1, rand_value());
                end
                n++;
            end
            while (first_fill != 0 || second_fill != 0) begin
                send_element(first_fill < t1 ? 1'b0 : 1'b1, rand_value());
                n++;
            end
        end
    endtask

    row_t plan[$];

    task automatic add_row(logic f, logic [31:0] v, bit g, logic [31:0] gv, logic ge,
                           logic gl);
        row_t r;
        r.func = f;
        r.value = v;
        r.has_gold = g;
        r.gold.result_value = gv;
        r.gold.dimension_error = ge;
        r.gold.last_result = gl;
        plan.push_back(r);
    endtask

    task automatic run_plan();
        int before_n;
        foreach (plan[i]) begin
            before_n = n_predicted;
            send_element(plan[i].func, plan[i].value);
            if (plan[i].has_gold && (n_predicted != before_n + 1 ||
                pending_results.size() == 0 || pending_results[$] !== plan[i].gold)) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row %0d: predictor disagrees with table", i);
            end
        end
        plan.delete();
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_off = 1'b0;
        n_predicted = 0;
        mismatches = 0;
        beats_in = 0;
        beats_out = 0;
        error_beats = 0;
        cycle_count = 0;
        sender_idle = 15;
        receiver_idle = 73;
        mx_op = OP_MUL;
        mx_r1 = 8; mx_c1 = 8; mx_r2 = 8; mx_c2 = 8;
        mx_scale = 32'sd65536;
        first_fill = 0;
        second_fill = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: add 1x1 extremes saturate, sub, scale, bad shapes, mul
        set_shape(OP_ADD, 1, 1, 1, 1, 32'h00010000);
        add_row(1'b0, 32'h7fffffff, 0, 0, 0, 0);
        add_row(1'b1, 32'h7fffffff, 1, 32'h7fffffff, 1'b0, 1'b1);
        add_row(1'b1, 32'h80000000, 0, 0, 0, 0);
        add_row(1'b1, 32'h00000005, 0, 0, 0, 0);
        add_row(1'b0, 32'h80000000, 1, 32'h80000000, 1'b0, 1'b1);
        run_plan();
        set_shape(OP_SUB, 1, 2, 1, 2, 32'h00010000);
        add_row(1'b0, 32'h80000000, 0, 0, 0, 0);
        add_row(1'b0, 32'h00000003, 0, 0, 0, 0);
        add_row(1'b1, 32'h00000001, 0, 0, 0, 0);
        add_row(1'b1, 32'h7fffffff, 0, 0, 0, 0);
        run_plan();
        set_shape(OP_SCALE, 2, 1, 15, 0, 32'h80000000);
        add_row(1'b1, 32'h12345678, 0, 0, 0, 0);
        add_row(1'b0, 32'h00010000, 0, 0, 0, 0);
        add_row(1'b0, 32'h80000000, 0, 0, 0, 0);
        run_plan();
        set_shape(OP_MUL, 2, 3, 2, 2, 32'h7fffffff);
        add_row(1'b0, 32'h00010000, 1, 32'h0, 1'b1, 1'b1);
        add_row(1'b1, 32'hffffffff, 1, 32'h0, 1'b1, 1'b1);
        run_plan();
        set_shape(OP_ADD, 0, 1, 0, 1, 32'h0);
        add_row(1'b0, 32'h1, 1, 32'h0, 1'b1, 1'b1);
        run_plan();
        set_shape(OP_MUL, 2, 2, 2, 1, 32'h0);
        for (int i = 0; i < 6; i++)
            add_row(i % 3 == 2, i[0] ? 32'h7fffffff : 32'h7fff0000 + i, 0, 0, 0, 0);
        run_plan();
        set_shape(OP_MUL, 8, 8, 8, 8, 32'h0);
        for (int i = 0; i < 128; i++)
            send_element(i[0], (i < 4) ? 32'hffff8000 : rand_value());

        random_phase(40);
        sender_idle = 73;
        receiver_idle = 15;
        random_phase(40);
        sender_idle = 0;
        receiver_idle = 0;
        // long hold-off while a full scale burst queues up behind the receiver
        set_shape(OP_SCALE, 4, 4, 1, 1, 32'h00018000);
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 48; i++) send_element(1'b0, rand_value());
        join
        random_phase(40);
        drain();
        $display("%0d elements in, %0d result beats out (%0d dimension errors)",
                 beats_in, beats_out, error_beats);
        $display("covered add, subtract, multiply and scale incl. saturation and bad shapes");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
